@@ sv/base64_stream_encoder_defines.svh @@
// Assertion macros shared by the Base64 encoder modules.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define B64E_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included.
`define B64E_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/b64e_pkg.sv @@
// Types, constants and the character table of the Base64 encoder.
package b64e_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned CharW         = 7;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CharW-1:0] PadChar = 7'h3D;  // '='

  // Position within the current three-byte group.
  typedef enum logic [2:0] {
    PhFirst  = 3'b001,
    PhSecond = 3'b010,
    PhThird  = 3'b100
  } phase_e;

  // One request's characters as handed from front to back.
  typedef struct packed {
    logic [3:0][CharW-1:0] chars;
    logic [1:0]            last_idx;  // index of the request's final character
    logic                  fin;       // request closes the message
  } job_t;

  // Map a sextet to its character of the standard alphabet.
  function automatic logic [CharW-1:0] b64_char(input logic [5:0] v);
    logic [CharW-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26)      return w + 7'd65;  // 'A'..'Z'
    else if (v < 6'd52) return w + 7'd71;  // 'a'..'z'
    else if (v < 6'd62) return w - 7'd4;   // '0'..'9'
    else if (v == 6'd62) return 7'h2B;     // '+'
    else                return 7'h2F;      // '/'
  endfunction

endpackage

@@ sv/b64e_if.sv @@
// Valid/ready stream interfaces for the byte input and character output.
interface b64e_byte_if import b64e_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b64e_char_if import b64e_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] code_char;
  logic             end_of_text;

  modport source (output valid, code_char, end_of_text, input ready);
  modport sink   (input valid, code_char, end_of_text, output ready);
endinterface

@@ sv/base64_stream_encoder.sv @@
// Top level of the Base64 stream encoder.
// Encodes a byte stream into standard Base64 characters with '=' padding.
// Input channel byte_i: one message byte per request, final_byte set on the
// last byte of a message. Output channel char_o: one ASCII character per
// request, end_of_text set on the last character of the encoded message.
// The first character of a byte is offered once it has passed the request
// queue and the output register. Throughput: the output register sends one
// character per cycle while a request waits and char_o.ready holds, so a
// byte gives one to four characters (two for the third byte of a group, four
// for a lone final byte), and that single output register sets the pace.
// The front end takes a byte every cycle while the request queue has room.
// Reset (rst_ni low, asynchronous) empties the queue, drops any character
// in flight and restarts at the first byte of a group.
// When the receiver stalls, the output character holds, the queue fills and
// byte_i.ready falls once QueueDepth requests are waiting.
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef  // at least 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  b64e_byte_if.sink   byte_i,
  b64e_char_if.source char_o
);

  // Front to queue.
  logic push, q_full;
  job_t job;

  // Queue to back.
  logic head_valid, pop;
  job_t head;

  // Classify each byte by its group phase and build its characters.
  b64e_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  // Decouple byte intake from character output.
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // Send the characters one by one; pop the request with its last one.
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .char_o       (char_o)
  );

endmodule

@@ sv/b64e_front.sv @@
// Front end: accept bytes, track the group phase, build character requests.
module b64e_front import b64e_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  b64e_byte_if.sink byte_i,
  input  logic  q_full_i,
  output logic  push_o,
  output job_t  job_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;
  logic       fin;

  assign byte_i.ready = !q_full_i;
  assign push_o       = byte_i.valid && !q_full_i;
  assign b            = byte_i.data_byte;
  assign fin          = byte_i.final_byte;

  always_comb begin
    job_o.fin      = fin;
    job_o.chars[2] = PadChar;
    job_o.chars[3] = PadChar;
    phase_d        = phase_q;
    carry_d        = carry_q;
    case (phase_q)
      PhSecond: begin
        job_o.chars[0] = b64_char({carry_q[1:0], b[7:4]});
        job_o.chars[1] = b64_char({b[3:0], 2'b00});
        job_o.last_idx = fin ? 2'd2 : 2'd0;
        phase_d        = PhThird;
        carry_d        = b[3:0];
      end
      PhThird: begin
        job_o.chars[0] = b64_char({carry_q, b[7:6]});
        job_o.chars[1] = b64_char(b[5:0]);
        job_o.last_idx = 2'd1;
        phase_d        = PhFirst;
        carry_d        = 4'd0;
      end
      default: begin
        job_o.chars[0] = b64_char(b[7:2]);
        job_o.chars[1] = b64_char({b[1:0], 4'b0000});
        job_o.last_idx = fin ? 2'd3 : 2'd0;
        phase_d        = PhSecond;
        carry_d        = {2'b00, b[1:0]};
      end
    endcase
    // Close the group at message end.
    if (fin) begin
      phase_d = PhFirst;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      carry_q <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

@@ sv/b64e_queue.sv @@
// Short request queue between the front and back ends.
`include "base64_stream_encoder_defines.svh"
module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef  // at least 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= advance(wr_q);
      if (pop_i)  rd_q <= advance(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `B64E_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntW'(Depth), "queue count beyond depth")
  `B64E_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `B64E_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from an empty queue")

endmodule

@@ sv/b64e_back.sv @@
// Back end: stream each request's characters through the output register.
`include "base64_stream_encoder_defines.svh"
module b64e_back import b64e_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  job_t head_i,
  output logic pop_o,
  b64e_char_if.source char_o
);

  logic [1:0]       idx_q;
  logic             ov_q;
  logic [CharW-1:0] char_q;
  logic             eot_q;
  logic             load, last_char;

  assign load      = head_valid_i && (!ov_q || char_o.ready);
  assign last_char = idx_q == head_i.last_idx;
  assign pop_o     = load && last_char;

  assign char_o.valid       = ov_q;
  assign char_o.code_char   = char_q;
  assign char_o.end_of_text = eot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last_char ? 2'd0 : idx_q + 2'd1;
        ov_q  <= 1'b1;
      end else if (char_o.ready) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      eot_q  <= head_i.fin && last_char;
    end
  end

  `B64E_ASSERT(a_idx_in_job, head_valid_i |-> idx_q <= head_i.last_idx, "index past request end")
  `B64E_ASSERT(a_idx_idle, !head_valid_i |-> idx_q == 2'd0, "index left over without request")

endmodule
